// ===== rtl/fdvs_pkg.sv =====
// Shared types and constants for the fill/drain valve sequencer.
// Used by fdvs_step and fill_drain_valve_sequencer_core; no dependencies.
package fdvs_pkg;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INLET_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_SWITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC_SWITCH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_DELAY   = 3'd4;

    localparam logic [CFG_W-1:0] RST_ZERO_LEVEL    = 16'd50;
    localparam logic [CFG_W-1:0] RST_INLET_TIMEOUT = 16'd300;
    localparam logic [CFG_W-1:0] RST_DRAIN_SWITCH  = 16'd5;
    localparam logic [CFG_W-1:0] RST_CIRC_SWITCH   = 16'd5;
    localparam logic [CFG_W-1:0] RST_DRAIN_DELAY   = 16'd10;

    // Request kinds
    localparam logic [1:0] REQ_FILL       = 2'd0;
    localparam logic [1:0] REQ_DRAIN      = 2'd1;
    localparam logic [1:0] REQ_STOP_FILL  = 2'd2;
    localparam logic [1:0] REQ_STOP_DRAIN = 2'd3;

    // Result status
    localparam logic [1:0] STAT_BUSY  = 2'd0;
    localparam logic [1:0] STAT_DONE  = 2'd1;
    localparam logic [1:0] STAT_FAULT = 2'd2;

    // Activity
    localparam logic [1:0] ACTV_IDLE  = 2'd0;
    localparam logic [1:0] ACTV_FILL  = 2'd1;
    localparam logic [1:0] ACTV_DRAIN = 2'd2;

    // Fill sequence steps
    localparam logic [2:0] FILL_CHECK = 3'd0;
    localparam logic [2:0] FILL_START = 3'd1;
    localparam logic [2:0] FILL_RUN   = 3'd2;
    localparam logic [2:0] FILL_FAULT = 3'd3;
    localparam logic [2:0] FILL_DONE  = 3'd4;

    // Drain sequence steps
    localparam logic [3:0] DR_SET_VALVE  = 4'd0;
    localparam logic [3:0] DR_VALVE_WAIT = 4'd1;
    localparam logic [3:0] DR_CIRC_OPEN  = 4'd2;
    localparam logic [3:0] DR_CIRC_WAIT  = 4'd3;
    localparam logic [3:0] DR_PUMP_ON    = 4'd4;
    localparam logic [3:0] DR_LEVEL_WAIT = 4'd5;
    localparam logic [3:0] DR_DELAY_WAIT = 4'd6;
    localparam logic [3:0] DR_STOP       = 4'd7;
    localparam logic [3:0] DR_CLOSE_WAIT = 4'd8;
    localparam logic [3:0] DR_DONE       = 4'd9;

    localparam logic [2:0] FINISH_READINGS = 3'd5;
    localparam logic [7:0] STALL_WINDOW    = 8'd150;
    localparam int         MIN_RISE        = 1;

    // Result item layout
    localparam int OUT_W      = 9;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [CFG_W-1:0] empty_offset;
        logic [CFG_W-1:0] inlet_timeout;
        logic [CFG_W-1:0] drain_switch;
        logic [CFG_W-1:0] circ_switch;
        logic [CFG_W-1:0] drain_delay;
    } t_cfg;

    typedef struct packed {
        logic [2:0] fill_step;
        logic [3:0] drain_step;
        logic [1:0] activity;
        logic       fault;
        logic [7:0] stall_count;
        logic [2:0] above_count;
        logic       inlet;
        logic       extract;
        logic       circ_valve;
        logic       pump;
    } t_ctrl;

endpackage

// ===== rtl/fdvs_step.sv =====
// Next-state logic for one request of the fill/drain valve sequencer.
// Purely combinational; depends on fdvs_pkg.
module fdvs_step import fdvs_pkg::*; #(
    parameter int TIME_BITS  = 32,
    parameter int LEVEL_BITS = 16
) (
    input  t_ctrl                 i_ctrl,
    input  t_cfg                  i_cfg,
    input  logic [TIME_BITS-1:0]  i_fill_start,
    input  logic [TIME_BITS-1:0]  i_drain_mark,
    input  logic [TIME_BITS-1:0]  i_delay_mark,
    input  logic [LEVEL_BITS-1:0] i_last_level,
    input  logic [1:0]            i_req_type,
    input  logic [LEVEL_BITS-1:0] i_target_volume,
    input  logic [LEVEL_BITS-1:0] i_level,
    input  logic [TIME_BITS-1:0]  i_now_seconds,
    input  logic                  i_drain_to_extract,
    output t_ctrl                 o_ctrl,
    output logic [TIME_BITS-1:0]  o_fill_start,
    output logic [TIME_BITS-1:0]  o_drain_mark,
    output logic [TIME_BITS-1:0]  o_delay_mark,
    output logic [LEVEL_BITS-1:0] o_last_level,
    output logic [1:0]            o_status
);

    logic [CFG_W:0]          fill_mark;
    logic                    below_mark;
    logic                    above_mark;
    logic [TIME_BITS-1:0]    fill_elapsed;
    logic [TIME_BITS-1:0]    drain_elapsed;
    logic [TIME_BITS-1:0]    delay_elapsed;
    logic signed [LEVEL_BITS:0] rise;
    logic [2:0]              above_inc;
    logic [7:0]              stall_inc;

    always_comb begin
        fill_mark     = {1'b0, i_cfg.empty_offset} + (CFG_W+1)'(i_target_volume);
        below_mark    = (CFG_W+1)'(i_level) < fill_mark;
        above_mark    = (CFG_W+1)'(i_level) > fill_mark;
        fill_elapsed  = i_now_seconds - i_fill_start;
        drain_elapsed = i_now_seconds - i_drain_mark;
        delay_elapsed = i_now_seconds - i_delay_mark;
        rise          = $signed({1'b0, i_level}) - $signed({1'b0, i_last_level});
        above_inc     = i_ctrl.above_count + 3'd1;
        stall_inc     = i_ctrl.stall_count + 8'd1;
    end

    always_comb begin
        o_ctrl       = i_ctrl;
        o_fill_start = i_fill_start;
        o_drain_mark = i_drain_mark;
        o_delay_mark = i_delay_mark;
        o_last_level = i_last_level;
        o_status     = STAT_BUSY;

        case (i_req_type)
            REQ_FILL: begin
                case (i_ctrl.fill_step)
                    FILL_CHECK: begin
                        o_ctrl.fill_step = below_mark ? FILL_START : FILL_DONE;
                    end
                    FILL_START: begin
                        o_ctrl.stall_count = '0;
                        o_ctrl.above_count = '0;
                        o_ctrl.activity    = ACTV_FILL;
                        o_ctrl.fill_step   = FILL_RUN;
                        o_ctrl.inlet       = 1'b1;
                        o_fill_start       = i_now_seconds;
                        o_last_level       = i_level;
                    end
                    FILL_RUN: begin
                        if (above_mark) begin
                            o_ctrl.above_count = above_inc;
                            if (above_inc > FINISH_READINGS) begin
                                o_ctrl.inlet     = 1'b0;
                                o_ctrl.fill_step = FILL_DONE;
                            end
                        end else begin
                            o_ctrl.above_count = '0;
                            o_ctrl.stall_count = stall_inc;
                            // Stall window closed: check that the level rose
                            if (stall_inc > STALL_WINDOW) begin
                                o_ctrl.stall_count = '0;
                                if (rise < $signed((LEVEL_BITS+1)'(MIN_RISE))) begin
                                    o_ctrl.fault     = 1'b1;
                                    o_ctrl.fill_step = FILL_FAULT;
                                    o_ctrl.inlet     = 1'b0;
                                end
                                o_last_level = i_level;
                            end
                            if (fill_elapsed > TIME_BITS'(i_cfg.inlet_timeout)) begin
                                o_ctrl.fault     = 1'b1;
                                o_ctrl.fill_step = FILL_FAULT;
                                o_ctrl.inlet     = 1'b0;
                            end
                        end
                    end
                    FILL_FAULT: begin
                        o_ctrl.inlet     = 1'b0;
                        o_ctrl.activity  = ACTV_IDLE;
                        o_ctrl.fill_step = FILL_CHECK;
                        o_status         = STAT_FAULT;
                    end
                    FILL_DONE: begin
                        o_ctrl.fill_step = FILL_CHECK;
                        o_status         = STAT_DONE;
                    end
                    default: begin
                        o_status = STAT_BUSY;
                    end
                endcase
            end
            REQ_DRAIN: begin
                case (i_ctrl.drain_step)
                    DR_SET_VALVE: begin
                        o_ctrl.activity   = ACTV_DRAIN;
                        o_ctrl.extract    = i_drain_to_extract;
                        o_drain_mark      = i_now_seconds;
                        o_ctrl.drain_step = DR_VALVE_WAIT;
                    end
                    DR_VALVE_WAIT: begin
                        if (drain_elapsed > TIME_BITS'(i_cfg.drain_switch)) begin
                            o_ctrl.drain_step = DR_CIRC_OPEN;
                        end
                    end
                    DR_CIRC_OPEN: begin
                        o_ctrl.circ_valve = 1'b1;
                        o_drain_mark      = i_now_seconds;
                        o_ctrl.drain_step = DR_CIRC_WAIT;
                    end
                    DR_CIRC_WAIT: begin
                        if (drain_elapsed > TIME_BITS'(i_cfg.circ_switch)) begin
                            o_ctrl.drain_step = DR_PUMP_ON;
                        end
                    end
                    DR_PUMP_ON: begin
                        o_ctrl.pump       = 1'b1;
                        o_ctrl.drain_step = DR_LEVEL_WAIT;
                    end
                    DR_LEVEL_WAIT: begin
                        if (CFG_W'(i_level) < i_cfg.empty_offset) begin
                            o_delay_mark      = i_now_seconds;
                            o_ctrl.drain_step = DR_DELAY_WAIT;
                        end
                    end
                    DR_DELAY_WAIT: begin
                        if (delay_elapsed > TIME_BITS'(i_cfg.drain_delay)) begin
                            o_ctrl.drain_step = DR_STOP;
                        end
                    end
                    DR_STOP: begin
                        o_ctrl.pump       = 1'b0;
                        o_ctrl.circ_valve = 1'b0;
                        o_drain_mark      = i_now_seconds;
                        o_ctrl.drain_step = DR_CLOSE_WAIT;
                    end
                    DR_CLOSE_WAIT: begin
                        if (drain_elapsed > TIME_BITS'(i_cfg.circ_switch)) begin
                            o_ctrl.drain_step = DR_DONE;
                        end
                    end
                    DR_DONE: begin
                        o_ctrl.extract    = 1'b0;
                        o_ctrl.drain_step = DR_SET_VALVE;
                        o_ctrl.activity   = ACTV_IDLE;
                        o_status          = STAT_DONE;
                    end
                    default: begin
                        o_status = STAT_BUSY;
                    end
                endcase
            end
            REQ_STOP_FILL: begin
                o_ctrl.inlet     = 1'b0;
                o_ctrl.activity  = ACTV_IDLE;
                o_ctrl.fill_step = FILL_CHECK;
            end
            REQ_STOP_DRAIN: begin
                o_ctrl.extract    = 1'b0;
                o_ctrl.pump       = 1'b0;
                o_ctrl.circ_valve = 1'b0;
                o_ctrl.activity   = ACTV_IDLE;
                o_ctrl.drain_step = DR_SET_VALVE;
            end
            default: begin
                o_status = STAT_BUSY;
            end
        endcase
    end

endmodule

// ===== rtl/fill_drain_valve_sequencer_core.sv =====
// Top level of the fill/drain valve sequencer: stream ports, configuration
// registers, sequence state and the result register. Depends on fdvs_pkg, fdvs_step.
//
// One request item in, one result item out. Each accepted item is worked
// combinationally: the step logic reads the sequence state and the item, the state
// registers and the result register load at the same edge, and the result is
// offered on the master side in the cycle after acceptance. The block takes one
// item per cycle; the only thing that holds it back is the single result
// register, so the slave side is ready whenever that register is empty or is
// being emptied in the same cycle. Configuration writes land at the edge where
// the write enable is high and are meant to happen only while the block is idle.
module fill_drain_valve_sequencer_core import fdvs_pkg::*; #(
    parameter int TIME_BITS  = 32,
    parameter int LEVEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Request items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata from bit 0: target_volume, level, now_seconds, drain_to_extract, zero fill
    input  logic [((2*LEVEL_BITS+TIME_BITS+1+7)/8)*8-1:0] i_s_tdata,
    // tuser: req_type
    input  logic [1:0]            i_s_tuser,
    // Result items
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata from bit 0: status, inlet_valve_open, drain_valve_extract,
    // circ_valve_open, circ_pump_on, activity, fault_latched, zero fill
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int TGT_LSB = 0;
    localparam int LVL_LSB = LEVEL_BITS;
    localparam int NOW_LSB = 2 * LEVEL_BITS;
    localparam int EXT_BIT = 2 * LEVEL_BITS + TIME_BITS;

    // Configuration and sequence state
    t_cfg                  r_cfg;
    t_ctrl                 r_ctrl;
    t_ctrl                 n_ctrl;
    logic [TIME_BITS-1:0]  r_fill_start;
    logic [TIME_BITS-1:0]  n_fill_start;
    logic [TIME_BITS-1:0]  r_drain_mark;
    logic [TIME_BITS-1:0]  n_drain_mark;
    logic [TIME_BITS-1:0]  r_delay_mark;
    logic [TIME_BITS-1:0]  n_delay_mark;
    logic [LEVEL_BITS-1:0] r_last_level;
    logic [LEVEL_BITS-1:0] n_last_level;

    // Result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [1:0]            n_status;

    logic                  in_accept;

    // Ready while the result register is free or draining this cycle
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    fdvs_step #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_step (
        .i_ctrl             (r_ctrl),
        .i_cfg              (r_cfg),
        .i_fill_start       (r_fill_start),
        .i_drain_mark       (r_drain_mark),
        .i_delay_mark       (r_delay_mark),
        .i_last_level       (r_last_level),
        .i_req_type         (i_s_tuser),
        .i_target_volume    (i_s_tdata[TGT_LSB +: LEVEL_BITS]),
        .i_level            (i_s_tdata[LVL_LSB +: LEVEL_BITS]),
        .i_now_seconds      (i_s_tdata[NOW_LSB +: TIME_BITS]),
        .i_drain_to_extract (i_s_tdata[EXT_BIT]),
        .o_ctrl             (n_ctrl),
        .o_fill_start       (n_fill_start),
        .o_drain_mark       (n_drain_mark),
        .o_delay_mark       (n_delay_mark),
        .o_last_level       (n_last_level),
        .o_status           (n_status)
    );

    // Pack the result item from the updated state
    always_comb begin
        n_out_data = {
            (OUT_DATA_W-OUT_W)'(0),
            n_ctrl.fault,
            n_ctrl.activity,
            n_ctrl.pump,
            n_ctrl.circ_valve,
            n_ctrl.extract,
            n_ctrl.inlet,
            n_status
        };
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.empty_offset  <= RST_ZERO_LEVEL;
            r_cfg.inlet_timeout <= RST_INLET_TIMEOUT;
            r_cfg.drain_switch  <= RST_DRAIN_SWITCH;
            r_cfg.circ_switch   <= RST_CIRC_SWITCH;
            r_cfg.drain_delay   <= RST_DRAIN_DELAY;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ZERO_LEVEL:    r_cfg.empty_offset  <= i_cfg_wdata;
                CFG_INLET_TIMEOUT: r_cfg.inlet_timeout <= i_cfg_wdata;
                CFG_DRAIN_SWITCH:  r_cfg.drain_switch  <= i_cfg_wdata;
                CFG_CIRC_SWITCH:   r_cfg.circ_switch   <= i_cfg_wdata;
                CFG_DRAIN_DELAY:   r_cfg.drain_delay   <= i_cfg_wdata;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Sequence control state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_ctrl <= n_ctrl;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Time marks, last level and result payload: always written before use
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fill_start <= n_fill_start;
            r_drain_mark <= n_drain_mark;
            r_delay_mark <= n_delay_mark;
            r_last_level <= n_last_level;
            r_out_data   <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // The fault flag never clears once set
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.fault |=> r_ctrl.fault)
        else $error("fault flag cleared");

    // The inlet is open exactly while the fill sequence is running
    a_inlet_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.inlet == (r_ctrl.fill_step == FILL_RUN))
        else $error("inlet valve out of step with fill sequence");

    // The pump only runs with the circulation valve open
    a_pump_circ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.pump |-> r_ctrl.circ_valve)
        else $error("pump on with circulation valve closed");

    // Every accepted item shows a result on the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    // A fault result always carries the latched fault flag
    a_fault_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[1:0] == STAT_FAULT)) |-> r_out_data[OUT_W-1])
        else $error("fault status without fault flag");
`endif

endmodule

// ===== tb/fill_drain_valve_sequencer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fill_drain_valve_sequencer_core: a scripted opening, then shaped random
// fill, drain and noise traffic scored against an in-bench sequencer predictor.
// Depends on fdvs_pkg and the core RTL only.
module fill_drain_valve_sequencer_core_test;
    import fdvs_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 400;
    localparam int DRAIN_CAP    = 120;
    localparam int FILL_CAP     = 400;

    // One result item, packed to match o_m_tdata[8:0]: status sits in the low bits.
    typedef struct packed {
        logic       fault;
        logic [1:0] activity;
        logic       pump;
        logic       circ;
        logic       extract;
        logic       inlet;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] target;
        logic [15:0] level;
        logic [31:0] now;
        logic        extract;
        bit          fixed;
        result_t     want;
    } script_row_t;

    typedef enum {RUN_NORMAL, RUN_SATISFIED, RUN_STALL, RUN_TIMEOUT} fill_plan_e;

    localparam result_t IDLE_RES    = '0;
    localparam result_t DONE_RES    = '{status: STAT_DONE, default: '0};
    localparam result_t FAULT_RES   = '{status: STAT_FAULT, fault: 1'b1, default: '0};
    localparam result_t LATCHED_RES = '{fault: 1'b1, default: '0};

    // Opening script, default registers: zero level 50, timeout 300, waits 5/5/10.
    // Rows marked fixed carry a hand-derived result; the others are scored by the predictor.
    localparam script_row_t SCRIPT [25] = '{
        // stops from reset, all-zero and all-ones fields
        '{REQ_STOP_FILL,  16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 1'b1, IDLE_RES},
        '{REQ_STOP_DRAIN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, IDLE_RES},
        // level already at the mark: finish without opening the inlet
        '{REQ_FILL,       16'h0000, 16'hFFFF, 32'd10,        1'b0, 1'b1, IDLE_RES},
        '{REQ_FILL,       16'h0000, 16'hFFFF, 32'd11,        1'b0, 1'b1, DONE_RES},
        // open the inlet, then run out the inlet timeout exactly at the boundary
        '{REQ_FILL,       16'hFFFF, 16'h0000, 32'd100,       1'b0, 1'b0, IDLE_RES},
        '{REQ_FILL,       16'hFFFF, 16'h0000, 32'd100,       1'b1, 1'b0, IDLE_RES},
        '{REQ_FILL,       16'hFFFF, 16'h0000, 32'd400,       1'b0, 1'b0, IDLE_RES},
        '{REQ_FILL,       16'hFFFF, 16'h0000, 32'd401,       1'b0, 1'b0, IDLE_RES},
        '{REQ_FILL,       16'hFFFF, 16'h0000, 32'd402,       1'b0, 1'b1, FAULT_RES},
        // drain to extract through every step up to the delay wait
        '{REQ_DRAIN,      16'h0000, 16'h1000, 32'd1000,      1'b1, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'h1000, 32'd1005,      1'b0, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'h1000, 32'd1006,      1'b0, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'h1000, 32'd1006,      1'b0, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'h1000, 32'd1011,      1'b0, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'h1000, 32'd1012,      1'b0, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'hFFFF, 32'd1012,      1'b0, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'd50,   32'd1015,      1'b0, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'd49,   32'd1020,      1'b0, 1'b0, IDLE_RES},
        '{REQ_STOP_DRAIN, 16'h0000, 16'h0000, 32'd1021,      1'b0, 1'b1, LATCHED_RES},
        // valve travel wait across the seconds counter wrap
        '{REQ_DRAIN,      16'h0000, 16'h0000, 32'hFFFF_FFFE, 1'b0, 1'b0, IDLE_RES},
        '{REQ_DRAIN,      16'h0000, 16'h0000, 32'h0000_0004, 1'b0, 1'b0, IDLE_RES},
        // target plus zero level above 16 bits must not wrap
        '{REQ_FILL,       16'hFFFF, 16'hFFFF, 32'd5,         1'b0, 1'b0, IDLE_RES},
        '{REQ_FILL,       16'hFFFF, 16'hFFFF, 32'd6,         1'b0, 1'b0, IDLE_RES},
        '{REQ_STOP_FILL,  16'h0000, 16'h0000, 32'd7,         1'b0, 1'b1, LATCHED_RES},
        '{REQ_STOP_DRAIN, 16'h0000, 16'h0000, 32'd8,         1'b0, 1'b1, LATCHED_RES}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata = '0;
    logic [1:0]           s_tuser = REQ_FILL;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    fill_drain_valve_sequencer_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor copy of the registers and of the sequencer state.
    logic [15:0] cfg_zero    = RST_ZERO_LEVEL;
    logic [15:0] cfg_timeout = RST_INLET_TIMEOUT;
    logic [15:0] cfg_dswitch = RST_DRAIN_SWITCH;
    logic [15:0] cfg_cswitch = RST_CIRC_SWITCH;
    logic [15:0] cfg_delay   = RST_DRAIN_DELAY;

    logic [2:0]  fill_ph   = FILL_CHECK;
    logic [3:0]  drain_ph  = DR_SET_VALVE;
    logic [1:0]  act_q     = ACTV_IDLE;
    logic        fault_q   = 1'b0;
    logic [15:0] ref_level = '0;
    logic [7:0]  stall_cnt = '0;
    logic [2:0]  above_cnt = '0;
    logic [31:0] fill_t0   = '0;
    logic [31:0] drain_t0  = '0;
    logic [31:0] delay_t0  = '0;
    logic        inlet_q   = 1'b0;
    logic        extract_q = 1'b0;
    logic        circ_q    = 1'b0;
    logic        pump_q    = 1'b0;

    result_t     valve_results_due [$];
    int          items_sent = 0;
    int          fail_count = 0;
    bit          tx_steady  = 1'b0;
    bit          rx_steady  = 1'b0;
    logic [31:0] clock_s    = '0;

    // Advance the sequencer model by one request and return the result it answers.
    function automatic result_t sequence_request(input logic [1:0] req, input logic [15:0] tgt,
                                                 input logic [15:0] lvl, input logic [31:0] now,
                                                 input logic ext);
        logic [16:0] mark;
        logic [31:0] since_fill;
        logic [1:0]  status;
        int          rise;
        status     = STAT_BUSY;
        mark       = {1'b0, tgt} + {1'b0, cfg_zero};
        since_fill = now - fill_t0;
        case (req)
            REQ_FILL: begin
                case (fill_ph)
                    FILL_CHECK: fill_ph = ({1'b0, lvl} < mark) ? FILL_START : FILL_DONE;
                    FILL_START: begin
                        stall_cnt = '0;
                        above_cnt = '0;
                        act_q     = ACTV_FILL;
                        fill_ph   = FILL_RUN;
                        inlet_q   = 1'b1;
                        fill_t0   = now;
                        ref_level = lvl;
                    end
                    FILL_RUN: begin
                        if ({1'b0, lvl} > mark) begin
                            above_cnt = above_cnt + 3'd1;
                            if (above_cnt > FINISH_READINGS) begin
                                inlet_q = 1'b0;
                                fill_ph = FILL_DONE;
                            end
                        end else begin
                            above_cnt = '0;
                            stall_cnt = stall_cnt + 8'd1;
                            // stall window over: the level must have risen since the last look
                            if (stall_cnt > STALL_WINDOW) begin
                                stall_cnt = '0;
                                rise = int'(lvl) - int'(ref_level);
                                if (rise < MIN_RISE) begin
                                    fault_q = 1'b1;
                                    fill_ph = FILL_FAULT;
                                    inlet_q = 1'b0;
                                end
                                ref_level = lvl;
                            end
                            if (since_fill > {16'h0, cfg_timeout}) begin
                                fault_q = 1'b1;
                                fill_ph = FILL_FAULT;
                                inlet_q = 1'b0;
                            end
                        end
                    end
                    FILL_FAULT: begin
                        inlet_q = 1'b0;
                        act_q   = ACTV_IDLE;
                        fill_ph = FILL_CHECK;
                        status  = STAT_FAULT;
                    end
                    FILL_DONE: begin
                        fill_ph = FILL_CHECK;
                        status  = STAT_DONE;
                    end
                    default: ;
                endcase
            end
            REQ_DRAIN: begin
                case (drain_ph)
                    DR_SET_VALVE: begin
                        act_q     = ACTV_DRAIN;
                        extract_q = ext;
                        drain_t0  = now;
                        drain_ph  = DR_VALVE_WAIT;
                    end
                    DR_VALVE_WAIT:
                        if (now - drain_t0 > {16'h0, cfg_dswitch}) drain_ph = DR_CIRC_OPEN;
                    DR_CIRC_OPEN: begin
                        circ_q   = 1'b1;
                        drain_t0 = now;
                        drain_ph = DR_CIRC_WAIT;
                    end
                    DR_CIRC_WAIT:
                        if (now - drain_t0 > {16'h0, cfg_cswitch}) drain_ph = DR_PUMP_ON;
                    DR_PUMP_ON: begin
                        pump_q   = 1'b1;
                        drain_ph = DR_LEVEL_WAIT;
                    end
                    DR_LEVEL_WAIT:
                        if (lvl < cfg_zero) begin
                            delay_t0 = now;
                            drain_ph = DR_DELAY_WAIT;
                        end
                    DR_DELAY_WAIT:
                        if (now - delay_t0 > {16'h0, cfg_delay}) drain_ph = DR_STOP;
                    DR_STOP: begin
                        pump_q   = 1'b0;
                        circ_q   = 1'b0;
                        drain_t0 = now;
                        drain_ph = DR_CLOSE_WAIT;
                    end
                    DR_CLOSE_WAIT:
                        if (now - drain_t0 > {16'h0, cfg_cswitch}) drain_ph = DR_DONE;
                    DR_DONE: begin
                        extract_q = 1'b0;
                        drain_ph  = DR_SET_VALVE;
                        act_q     = ACTV_IDLE;
                        status    = STAT_DONE;
                    end
                    default: ;
                endcase
            end
            REQ_STOP_FILL: begin
                inlet_q = 1'b0;
                act_q   = ACTV_IDLE;
                fill_ph = FILL_CHECK;
            end
            default: begin
                extract_q = 1'b0;
                pump_q    = 1'b0;
                circ_q    = 1'b0;
                act_q     = ACTV_IDLE;
                drain_ph  = DR_SET_VALVE;
            end
        endcase
        return '{fault: fault_q, activity: act_q, pump: pump_q, circ: circ_q,
                 extract: extract_q, inlet: inlet_q, status: status};
    endfunction

    function automatic int clamp_level(input int lvl);
        return (lvl < 0) ? 0 : (lvl > 65535) ? 65535 : lvl;
    endfunction

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // Offer one request item after a random gap, hold it until accepted, then queue its result.
    task automatic send_req(input logic [1:0] req, input logic [15:0] tgt, input logic [15:0] lvl,
                            input logic [31:0] now, input logic ext,
                            input bit fixed = 1'b0, input result_t fixed_want = '0);
        int      gap;
        result_t predicted;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'b0, ext, now, lvl, tgt};
        do @(posedge clk); while (s_tready !== 1'b1);
        predicted = sequence_request(req, tgt, lvl, now, ext);
        valve_results_due.push_back(fixed ? fixed_want : predicted);
        items_sent++;
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (valve_results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ZERO_LEVEL:    cfg_zero    = val;
            CFG_INLET_TIMEOUT: cfg_timeout = val;
            CFG_DRAIN_SWITCH:  cfg_dswitch = val;
            CFG_CIRC_SWITCH:   cfg_cswitch = val;
            default:           cfg_delay   = val;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] z, input logic [15:0] t, input logic [15:0] ds,
                                input logic [15:0] cs, input logic [15:0] dd);
        write_reg(CFG_ZERO_LEVEL, z);
        write_reg(CFG_INLET_TIMEOUT, t);
        write_reg(CFG_DRAIN_SWITCH, ds);
        write_reg(CFG_CIRC_SWITCH, cs);
        write_reg(CFG_DRAIN_DELAY, dd);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // One fill sequence from the check step until it answers finished or fault,
    // shaped by the plan; an occasional early stop, and a stop if it never ends.
    task automatic fill_run(input fill_plan_e plan);
        int tgt, lvl, mark, top, n, abort_at;
        tgt  = $urandom_range(0, 3000);
        mark = tgt + int'(cfg_zero);
        top  = (mark > 65535) ? 65535 : mark;
        if (plan == RUN_SATISFIED) lvl = $urandom_range(top, 65535);
        else lvl = (top == 0) ? 0 : $urandom_range(0, top - 1);
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : -1;
        n = 0;
        do begin
            if (n == abort_at) break;
            send_req(REQ_FILL, tgt[15:0], lvl[15:0], clock_s, 1'($urandom_range(0, 1)));
            n++;
            case (plan)
                RUN_STALL: begin
                    // hover around the start level so the stall window sometimes trips
                    clock_s += $urandom_range(0, 1);
                    lvl = clamp_level(lvl + int'($urandom_range(0, 2)) - 1);
                    if (lvl > top) lvl = top;
                end
                RUN_TIMEOUT: begin
                    clock_s += $urandom_range(0, int'(cfg_timeout) / 4 + 3);
                    lvl = clamp_level(lvl + int'($urandom_range(0, 1)));
                    if (lvl > top) lvl = top;
                end
                default: begin
                    clock_s += $urandom_range(0, 2);
                    lvl = clamp_level(lvl + int'($urandom_range(0, 400)));
                end
            endcase
        end while (fill_ph != FILL_CHECK && n < FILL_CAP);
        if (fill_ph != FILL_CHECK)
            send_req(REQ_STOP_FILL, 16'($urandom_range(0, 65535)), lvl[15:0], clock_s,
                     1'($urandom_range(0, 1)));
    endtask

    // One drain sequence: mostly small time steps with the odd long jump so that
    // even the longest valve waits run out; the level falls once the pump runs.
    task automatic drain_run();
        int   lvl, n, abort_at;
        logic ext;
        ext      = 1'($urandom_range(0, 1));
        lvl      = $urandom_range(0, 65535);
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : -1;
        n = 0;
        do begin
            if (n == abort_at) break;
            send_req(REQ_DRAIN, 16'($urandom_range(0, 65535)), lvl[15:0], clock_s, ext);
            n++;
            clock_s += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 140000)
                                                   : $urandom_range(0, 3);
            if (pump_q) lvl = clamp_level(lvl - int'($urandom_range(0, 3000)));
        end while (drain_ph != DR_SET_VALVE && n < DRAIN_CAP);
        if (drain_ph != DR_SET_VALVE)
            send_req(REQ_STOP_DRAIN, 16'($urandom_range(0, 65535)), lvl[15:0], clock_s, ext);
    endtask

    // Any request kind with fields drawn over their full range.
    task automatic noise_burst();
        int          n;
        logic [31:0] now;
        n = $urandom_range(1, 8);
        repeat (n) begin
            now = ($urandom_range(0, 1) == 0) ? $urandom() : clock_s;
            send_req(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), now, 1'($urandom_range(0, 1)));
            clock_s += $urandom_range(0, 3);
        end
    endtask

    // Result side: stall for a random gap before each item, then score what arrives.
    initial begin : result_sink
        int      stall;
        result_t got;
        result_t want;
        wait (rst_n === 1'b1);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            @(negedge clk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got = result_t'(m_tdata[8:0]);
            if (valve_results_due.size() == 0) begin
                flag_failure($sformatf("result item with none due: %p", got));
            end else begin
                want = valve_results_due.pop_front();
                if (got.status !== want.status || got.inlet !== want.inlet
                    || got.extract !== want.extract || got.circ !== want.circ
                    || got.pump !== want.pump || got.activity !== want.activity
                    || got.fault !== want.fault)
                    flag_failure($sformatf("result mismatch: expected %p, got %p", want, got));
            end
        end
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int pick;
        int phase;
        int next_phase_at;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(SCRIPT); i++)
            send_req(SCRIPT[i].req, SCRIPT[i].target, SCRIPT[i].level, SCRIPT[i].now,
                     SCRIPT[i].extract, SCRIPT[i].fixed, SCRIPT[i].want);

        // Random part in register phases: reset values, all zero, all ones,
        // moderate values, then anything. Each switch waits for the block to drain.
        phase         = 0;
        next_phase_at = items_sent + PHASE_ITEMS;
        clock_s       = $urandom();
        while (items_sent < $size(SCRIPT) + RANDOM_ITEMS) begin
            if (items_sent >= next_phase_at) begin
                settle();
                phase++;
                next_phase_at += PHASE_ITEMS;
                case (phase)
                    1: begin
                        apply_config('0, '0, '0, '0, '0);
                        clock_s = 32'hFFFF_0000;
                    end
                    2: apply_config('1, '1, '1, '1, '1);
                    3: apply_config(16'($urandom_range(0, 600)), 16'($urandom_range(50, 400)),
                                    16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                                    16'($urandom_range(0, 20)));
                    default: apply_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                          16'($urandom()), 16'($urandom()));
                endcase
            end
            // some stretches run with no gaps on one or both sides
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 30)      fill_run(RUN_NORMAL);
            else if (pick < 36) fill_run(RUN_SATISFIED);
            else if (pick < 42) fill_run(RUN_STALL);
            else if (pick < 50) fill_run(RUN_TIMEOUT);
            else if (pick < 78) drain_run();
            else                noise_burst();
        end

        settle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
